// File: rtl/c2z_pkg.sv
package c2z_pkg;

  // register map of the configuration port
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_UL  = 3'd0,
    CFG_COEF_UR  = 3'd1,
    CFG_COEF_LL  = 3'd2,
    CFG_COEF_LR  = 3'd3,
    CFG_WIDTH    = 3'd4,
    CFG_HEIGHT   = 3'd5
  } cfg_idx_e;

  localparam int unsigned HEIGHT_BITS = 16;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

  // depth of the decoupling queue and of the result queue, power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH) + 1;

endpackage

// File: rtl/c2z_fifo.sv
module c2z_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = PW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          empty_o,
  output logic [CW-1:0] cnt_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// File: rtl/c2z_front.sv
module c2z_front
  import c2z_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16,
  localparam int unsigned AW        = $clog2(MAX_WIDTH),
  localparam int unsigned CW        = AW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_i,
  output logic                         full_o,
  input  logic [CW-1:0]                width_i,
  input  logic [HEIGHT_BITS-1:0]       height_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic signed [PIXEL_BITS-1:0] pix_o,
  output logic signed [PIXEL_BITS-1:0] above_o,
  output logic signed [PIXEL_BITS-1:0] left_o,
  output logic signed [PIXEL_BITS-1:0] upleft_o,
  output logic                         last_o
);

  // line buffer, one read and one write per accepted pixel at the same column
  logic [PIXEL_BITS-1:0] line_q [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_q;

  logic                   s1_valid_q;
  logic [PIXEL_BITS-1:0]  s1_pix_q;
  logic                   s1_col_nz_q, s1_row_nz_q, s1_last_q;
  logic [AW-1:0]          col_q;
  logic [HEIGHT_BITS-1:0] row_q;
  logic [PIXEL_BITS-1:0]  left_q, upleft_q;

  logic                   accept, advance, row_end, frame_end;
  logic [CW-1:0]          width_eff, width_m1;
  logic [HEIGHT_BITS-1:0] height_m1;
  logic [PIXEL_BITS-1:0]  above;

  always_comb begin
    if (width_i == '0) begin
      width_eff = CW'(1);
    end else if (width_i > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_i;
    end
    width_m1  = width_eff - CW'(1);
    height_m1 = (height_i == '0) ? '0 : height_i - HEIGHT_BITS'(1);
    row_end   = ({1'b0, col_q} >= width_m1);
    frame_end = row_end && (row_q >= height_m1);
  end

  assign advance  = s1_valid_q && !q_full_i;
  assign full_o   = s1_valid_q && !advance;
  assign accept   = push_i && !full_o;

  assign above    = s1_row_nz_q ? rd_q : '0;
  assign q_push_o = advance;
  assign pix_o    = s1_pix_q;
  assign above_o  = above;
  assign left_o   = s1_col_nz_q ? left_q : '0;
  assign upleft_o = s1_col_nz_q ? upleft_q : '0;
  assign last_o   = s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      upleft_q   <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (accept) begin
        if (row_end) begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_q + HEIGHT_BITS'(1);
        end else begin
          col_q <= col_q + AW'(1);
        end
      end
      if (advance) begin
        left_q   <= s1_pix_q;
        upleft_q <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q[col_q] <= pixel_i;
      rd_q          <= line_q[col_q];
      s1_pix_q      <= pixel_i;
      s1_col_nz_q   <= (col_q != '0);
      s1_row_nz_q   <= (row_q != '0);
      s1_last_q     <= frame_end;
    end
  end

endmodule

// File: rtl/c2z_back.sv
module c2z_back
  import c2z_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16,
  localparam int unsigned PB        = PIXEL_BITS + COEF_BITS,
  localparam int unsigned OUT_BITS  = PB + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  input  logic signed [PIXEL_BITS-1:0] pix_i,
  input  logic signed [PIXEL_BITS-1:0] above_i,
  input  logic signed [PIXEL_BITS-1:0] left_i,
  input  logic signed [PIXEL_BITS-1:0] upleft_i,
  input  logic                         last_i,
  input  logic signed [COEF_BITS-1:0]  coef_ul_i,
  input  logic signed [COEF_BITS-1:0]  coef_ur_i,
  input  logic signed [COEF_BITS-1:0]  coef_ll_i,
  input  logic signed [COEF_BITS-1:0]  coef_lr_i,
  input  logic [QUEUE_CNT_W-1:0]       res_cnt_i,
  output logic                         res_push_o,
  output logic [OUT_BITS-1:0]          sum_o,
  output logic                         last_o
);

  logic                 m_valid_q, m_last_q;
  logic signed [PB-1:0] p_ul_q, p_ur_q, p_ll_q, p_lr_q;

  // credit check: result queue entries plus the item in the product stage
  assign q_pop_o = !q_empty_i &&
                   ((res_cnt_i + QUEUE_CNT_W'(m_valid_q)) < QUEUE_CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      p_ul_q   <= upleft_i * coef_ul_i;
      p_ur_q   <= above_i * coef_ur_i;
      p_ll_q   <= left_i * coef_ll_i;
      p_lr_q   <= pix_i * coef_lr_i;
      m_last_q <= last_i;
    end
  end

  assign res_push_o = m_valid_q;
  assign last_o     = m_last_q;
  assign sum_o      = {{2{p_ul_q[PB-1]}}, p_ul_q} + {{2{p_ur_q[PB-1]}}, p_ur_q}
                    + {{2{p_ll_q[PB-1]}}, p_ll_q} + {{2{p_lr_q[PB-1]}}, p_lr_q};

endmodule

// File: rtl/conv2d_2x2_zero_border.sv
// Each pixel passes the front register, decoupling queue, product registers and result queue.
// Throughput: one pixel per cycle while full is low; one line buffer read and write per pixel.
// Line buffer reads are registered, products are registered, the sum is written to a 4-deep queue.
// Reset (rst_ni, async, active low) empties all queues, zeroes row/column/neighbor state and
// loads the register defaults; the line buffer is not cleared.
module conv2d_2x2_zero_border
  import c2z_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16,
  localparam int unsigned AW        = $clog2(MAX_WIDTH),
  localparam int unsigned CW        = AW + 1,
  localparam int unsigned OUT_BITS  = PIXEL_BITS + COEF_BITS + 2,
  localparam int unsigned DW1       = (COEF_BITS > CW) ? COEF_BITS : CW,
  localparam int unsigned CFG_DW    = (DW1 > HEIGHT_BITS) ? DW1 : HEIGHT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [PIXEL_BITS-1:0] pixel_in_i,
  input  logic                         pop,
  output logic                         empty,
  output logic signed [OUT_BITS-1:0]   filtered_value_o,
  output logic                         frame_last_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DW-1:0]            cfg_wdata_i
);

  localparam int unsigned MQ_DW = 4 * PIXEL_BITS + 1;
  localparam int unsigned RQ_DW = OUT_BITS + 1;

  logic signed [COEF_BITS-1:0] coef_ul_q, coef_ur_q, coef_ll_q, coef_lr_q;
  logic [CW-1:0]               width_q;
  logic [HEIGHT_BITS-1:0]      height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_ul_q <= COEF_BITS'(1 << (COEF_BITS - 2));
      coef_ur_q <= COEF_BITS'(1 << (COEF_BITS - 2));
      coef_ll_q <= COEF_BITS'(1 << (COEF_BITS - 2));
      coef_lr_q <= COEF_BITS'(1 << (COEF_BITS - 2));
      width_q   <= CW'(MAX_WIDTH);
      height_q  <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_UL: coef_ul_q <= cfg_wdata_i[COEF_BITS-1:0];
        CFG_COEF_UR: coef_ur_q <= cfg_wdata_i[COEF_BITS-1:0];
        CFG_COEF_LL: coef_ll_q <= cfg_wdata_i[COEF_BITS-1:0];
        CFG_COEF_LR: coef_lr_q <= cfg_wdata_i[COEF_BITS-1:0];
        CFG_WIDTH:   width_q   <= cfg_wdata_i[CW-1:0];
        CFG_HEIGHT:  height_q  <= cfg_wdata_i[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic                         mq_push, mq_full, mq_empty, mq_pop;
  logic signed [PIXEL_BITS-1:0] f_pix, f_above, f_left, f_upleft;
  logic                         f_last;
  logic [MQ_DW-1:0]             mq_rdata;
  logic [QUEUE_CNT_W-1:0]       mq_cnt;

  c2z_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pixel_i (pixel_in_i),
    .full_o  (full),
    .width_i (width_q),
    .height_i(height_q),
    .q_full_i(mq_full),
    .q_push_o(mq_push),
    .pix_o   (f_pix),
    .above_o (f_above),
    .left_o  (f_left),
    .upleft_o(f_upleft),
    .last_o  (f_last)
  );

  c2z_fifo #(
    .DW   (MQ_DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mq_push),
    .wdata_i({f_last, f_upleft, f_left, f_above, f_pix}),
    .full_o (mq_full),
    .pop_i  (mq_pop),
    .rdata_o(mq_rdata),
    .empty_o(mq_empty),
    .cnt_o  (mq_cnt)
  );

  logic                   rq_push, rq_full, b_last;
  logic [OUT_BITS-1:0]    b_sum;
  logic [RQ_DW-1:0]       rq_rdata;
  logic [QUEUE_CNT_W-1:0] rq_cnt;

  c2z_back #(
    .PIXEL_BITS(PIXEL_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (mq_empty),
    .q_pop_o   (mq_pop),
    .pix_i     (mq_rdata[PIXEL_BITS-1:0]),
    .above_i   (mq_rdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .left_i    (mq_rdata[3*PIXEL_BITS-1:2*PIXEL_BITS]),
    .upleft_i  (mq_rdata[4*PIXEL_BITS-1:3*PIXEL_BITS]),
    .last_i    (mq_rdata[4*PIXEL_BITS]),
    .coef_ul_i (coef_ul_q),
    .coef_ur_i (coef_ur_q),
    .coef_ll_i (coef_ll_q),
    .coef_lr_i (coef_lr_q),
    .res_cnt_i (rq_cnt),
    .res_push_o(rq_push),
    .sum_o     (b_sum),
    .last_o    (b_last)
  );

  c2z_fifo #(
    .DW   (RQ_DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .wdata_i({b_last, b_sum}),
    .full_o (rq_full),
    .pop_i  (pop),
    .rdata_o(rq_rdata),
    .empty_o(empty),
    .cnt_o  (rq_cnt)
  );

  assign filtered_value_o = rq_rdata[OUT_BITS-1:0];
  assign frame_last_o     = rq_rdata[OUT_BITS];

`ifndef SYNTHESIS
  // the front never pushes into a full decoupling queue
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_push |-> !mq_full) else $error("decoupling queue overflow");

  // credit scheme keeps the result queue from dropping a transfer
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push |-> !rq_full) else $error("result queue overflow");

  // a pop from the decoupling queue always lands in the result queue next cycle
  a_pop_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_pop |=> rq_push) else $error("back end lost an item");

  // queue occupancy never exceeds its depth
  a_mid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_cnt <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("decoupling queue count out of range");
`endif

endmodule

// File: verif/conv2d_2x2_zero_border_checker.sv
module conv2d_2x2_zero_border_checker
  import c2z_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic signed [15:0]   pixel_in_i,
  input  logic                 pop_i,
  input  logic                 empty_i,
  input  logic signed [33:0]   filtered_value_i,
  input  logic                 frame_last_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned MAX_COLS = 1024;

  typedef struct {
    logic signed [33:0] value;
    logic               last;
  } conv_result_t;

  conv_result_t expected_sums[$];

  logic signed [15:0] coef_ul, coef_ur, coef_ll, coef_lr;
  logic [10:0]        img_width;
  logic [15:0]        img_height;

  logic signed [15:0] row_store [MAX_COLS];
  logic signed [15:0] left_pix, upleft_pix;
  int unsigned        col_pos;
  logic [15:0]        row_pos;

  function automatic conv_result_t convolve_pixel(logic signed [15:0] pix);
    conv_result_t res;
    int unsigned  w;
    int unsigned  h;
    logic signed [15:0] above;
    logic signed [15:0] left;
    logic signed [15:0] upl;
    longint       sum;
    w = (img_width == 0) ? 1 : ((img_width > MAX_COLS) ? MAX_COLS : img_width);
    h = (img_height == 0) ? 1 : img_height;
    above = (row_pos > 0) ? row_store[col_pos] : '0;
    left  = (col_pos > 0) ? left_pix : '0;
    upl   = (col_pos > 0) ? upleft_pix : '0;
    sum = longint'(upl) * longint'(coef_ul) + longint'(above) * longint'(coef_ur)
        + longint'(left) * longint'(coef_ll) + longint'(pix) * longint'(coef_lr);
    row_store[col_pos] = pix;
    left_pix   = pix;
    upleft_pix = above;
    res.value = sum[33:0];
    res.last  = 1'b0;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) begin
        res.last = 1'b1;
        row_pos  = '0;
      end else begin
        row_pos = row_pos + 16'd1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_result_t want;
    if (!rst_ni) begin
      coef_ul    = 16'sd16384;
      coef_ur    = 16'sd16384;
      coef_ll    = 16'sd16384;
      coef_lr    = 16'sd16384;
      img_width  = 11'd1024;
      img_height = HEIGHT_RESET;
      left_pix   = '0;
      upleft_pix = '0;
      col_pos    = 0;
      row_pos    = '0;
      expected_sums.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COEF_UL: coef_ul    = cfg_wdata_i;
          CFG_COEF_UR: coef_ur    = cfg_wdata_i;
          CFG_COEF_LL: coef_ll    = cfg_wdata_i;
          CFG_COEF_LR: coef_lr    = cfg_wdata_i;
          CFG_WIDTH:   img_width  = cfg_wdata_i[10:0];
          CFG_HEIGHT:  img_height = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        expected_sums.push_back(convolve_pixel(pixel_in_i));
      end
      if (pop_i && !empty_i) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result, actual value %0d last %0b",
                   $time, filtered_value_i, frame_last_i);
          fail_count_o++;
        end else begin
          want = expected_sums.pop_front();
          if (want.value !== filtered_value_i) begin
            $display("%0t: filtered_value expected %0d actual %0d",
                     $time, want.value, filtered_value_i);
            fail_count_o++;
          end
          if (want.last !== frame_last_i) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.last, frame_last_i);
            fail_count_o++;
          end
        end
      end
      pending_o <= expected_sums.size();
    end
  end

endmodule

// File: verif/conv2d_2x2_zero_border_tb.sv
module conv2d_2x2_zero_border_tb
  import c2z_pkg::*;
();

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic signed [15:0]   pixel_in;
  logic                 pop;
  logic                 empty;
  logic signed [33:0]   filtered_value;
  logic                 frame_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_wdata;

  int fail_count;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_req;
  bit   hold_done;

  conv2d_2x2_zero_border dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .pixel_in_i       (pixel_in),
    .pop              (pop),
    .empty            (empty),
    .filtered_value_o (filtered_value),
    .frame_last_o     (frame_last),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  conv2d_2x2_zero_border_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .pixel_in_i       (pixel_in),
    .pop_i            (pop),
    .empty_i          (empty),
    .filtered_value_i (filtered_value),
    .frame_last_i     (frame_last),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("conv2d_2x2_zero_border_tb NOT OK");
    $finish;
  end

  function automatic logic signed [15:0] pick_extreme_or_random();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned eff_size(int unsigned v, int unsigned cap);
    return (v == 0) ? 1 : ((v > cap) ? cap : v);
  endfunction

  // writes all six registers back to back; cfg_we drops after the last one
  task automatic set_config(logic signed [15:0] ul, logic signed [15:0] ur,
                            logic signed [15:0] ll, logic signed [15:0] lr,
                            logic [15:0] w, logic [15:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_COEF_UL;
    cfg_wdata <= ul;
    @(posedge clk);
    cfg_idx   <= CFG_COEF_UR;
    cfg_wdata <= ur;
    @(posedge clk);
    cfg_idx   <= CFG_COEF_LL;
    cfg_wdata <= ll;
    @(posedge clk);
    cfg_idx   <= CFG_COEF_LR;
    cfg_wdata <= lr;
    @(posedge clk);
    cfg_idx   <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pixel(logic signed [15:0] v);
    push     <= 1'b1;
    pixel_in <= v;
    do @(posedge clk); while (full);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_pixels(int unsigned n);
    repeat (n) send_pixel(pick_extreme_or_random());
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random pop, one long hold-off on request
  initial begin
    pop = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (299) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    push        = 1'b0;
    pixel_in    = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_COEF_UL;
    cfg_wdata   = '0;
    hold_req    = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 45;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default weights, pixel extremes on a 3x2 frame
    set_config(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'd3, 16'd2);
    send_pixel(16'sd32767);
    send_pixel(-16'sd32768);
    send_pixel(16'sd32767);
    send_pixel(-16'sd32768);
    send_pixel(16'sd32767);
    send_pixel(-16'sd32768);
    wait_drained();

    // full window of most negative values reaches the largest sum,
    // then the width shrinks below the column in the middle of a frame
    set_config(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'd4, 16'd3);
    repeat (6) send_pixel(-16'sd32768);
    wait_drained();
    set_config(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'd1, 16'd3);
    send_pixel(16'sd0);
    send_pixel(-16'sd1);
    wait_drained();

    // tallest frame, cut short by height zero (acts as one) mid-frame
    set_config(16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'd2, 16'hFFFF);
    send_random_pixels(4);
    wait_drained();
    set_config(16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'd2, 16'd0);
    send_random_pixels(2);
    wait_drained();

    // width zero acts as one
    set_config(pick_extreme_or_random(), pick_extreme_or_random(),
               pick_extreme_or_random(), pick_extreme_or_random(), 16'd0, 16'd2);
    send_random_pixels(2);
    wait_drained();

    // receiver stalls long enough to back up the input
    set_config(pick_extreme_or_random(), pick_extreme_or_random(),
               pick_extreme_or_random(), pick_extreme_or_random(), 16'd20, 16'd3);
    hold_req <= 1'b1;
    send_random_pixels(60);
    wait_drained();

    random_sent = 0;
    while (random_sent < 420) begin
      if (random_sent < 140) begin
        tx_idle_pct = 15;
        rx_idle_pct = 45;
      end else if (random_sent < 280) begin
        tx_idle_pct = 45;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(0, 9))
        0: w = 0;
        1, 2: w = $urandom_range(13, 64);
        default: w = $urandom_range(1, 12);
      endcase
      h = (w > 12) ? $urandom_range(0, 3) : $urandom_range(0, 6);
      frames = $urandom_range(1, 2);
      // upper bits beyond the width field are don't-care
      set_config(pick_extreme_or_random(), pick_extreme_or_random(),
                 pick_extreme_or_random(), pick_extreme_or_random(),
                 {5'($urandom), 11'(w)}, 16'(h));
      send_random_pixels(eff_size(w, 1024) * eff_size(h, 65535) * frames);
      random_sent += eff_size(w, 1024) * eff_size(h, 65535) * frames;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("conv2d_2x2_zero_border_tb OK");
    end else begin
      $display("conv2d_2x2_zero_border_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: conv2d_2x2_zero_border.f
rtl/c2z_pkg.sv
rtl/c2z_fifo.sv
rtl/c2z_front.sv
rtl/c2z_back.sv
rtl/conv2d_2x2_zero_border.sv
verif/conv2d_2x2_zero_border_checker.sv
verif/conv2d_2x2_zero_border_tb.sv
